@@ rtl/modem_urc_notice_parser_assert.svh @@
// Assertion macros shared by the checker of the notice parser.
`ifndef MODEM_URC_NOTICE_PARSER_ASSERT_SVH
`define MODEM_URC_NOTICE_PARSER_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define URCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define URCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/urcp_pkg.sv @@
package urcp_pkg;

  localparam int LINE_LIMIT   = 64;
  localparam int LEN_W        = $clog2(LINE_LIMIT + 1);
  localparam int PREFIX_LEN   = 8;
  localparam int PREFIX_IDX_W = 3;
  localparam int NUM_W        = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Word held in the input stage.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_word_t;

  // Expected text "+NSONMI:" by position.
  function automatic logic [7:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h4E;
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h4E;
      3'd5:    c = 8'h4D;
      3'd6:    c = 8'h49;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/urcp_in_stage.sv @@
module urcp_in_stage import urcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output stage_word_t stage_o,
  input  logic        take_i
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // Refill in the same cycle the held word moves on.
  assign in_ready  = !valid_r || take_i;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign stage_o.valid   = valid_r;
  assign stage_o.rx_byte = byte_r;

endmodule

@@ rtl/urcp_parser.sv @@
module urcp_parser import urcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  stage_word_t      stage_i,
  output logic             take_o,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] out_socket_id,
  output logic [NUM_W-1:0] out_byte_count,
  output logic             out_count_present
);

  localparam logic [LEN_W-1:0] LenLimit  = LEN_W'(LINE_LIMIT);
  localparam logic [LEN_W-1:0] LenPrefix = LEN_W'(PREFIX_LEN);
  localparam logic [NUM_W+3:0] NumMax    = {4'd0, {NUM_W{1'b1}}};

  typedef struct packed {
    logic [NUM_W-1:0] acc;
    logic             started;
    logic             done;
  } num_t;

  // Accumulate a digit, skip a leading space, or end the number.
  function automatic num_t num_step(input num_t cur, input logic [7:0] b);
    num_t             res;
    logic [NUM_W+3:0] wide;
    res  = cur;
    wide = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + (NUM_W+4)'(b - CH_ZERO);
    if (b >= CH_ZERO && b <= CH_NINE) begin
      res.acc     = (wide > NumMax) ? {NUM_W{1'b1}} : wide[NUM_W-1:0];
      res.started = 1'b1;
    end else if (b == CH_SPACE && !cur.started) begin
      res.done = cur.done;
    end else begin
      res.done = 1'b1;
    end
    return res;
  endfunction

  logic             en_r;
  logic             prev_nl_r, prev_nl_nxt;
  logic             in_notice_r, in_notice_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             match_r, match_nxt;
  logic             comma_r, comma_nxt;
  num_t             sock_r, sock_nxt;
  num_t             cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0] sock_out_r, cnt_out_r;
  logic             present_out_r;

  logic       fire;
  logic       emit;
  logic       active;
  logic [7:0] b;

  assign b      = stage_i.rx_byte;
  assign take_o = stage_i.valid && (!out_valid_r || out_ready);
  assign fire   = take_o;
  assign active = in_notice_r || (prev_nl_r && b == CH_PLUS);

  always_comb begin
    prev_nl_nxt   = prev_nl_r;
    in_notice_nxt = in_notice_r;
    len_nxt       = len_r;
    match_nxt     = match_r;
    comma_nxt     = comma_r;
    sock_nxt      = sock_r;
    cnt_nxt       = cnt_r;
    emit          = 1'b0;
    if (fire) begin
      prev_nl_nxt   = (b == CH_LF);
      in_notice_nxt = active;
      if (active) begin
        priority if (b == CH_CR) begin
          emit          = en_r && (len_r >= LenPrefix) && match_r;
          in_notice_nxt = 1'b0;
          len_nxt       = '0;
          match_nxt     = 1'b1;
          comma_nxt     = 1'b0;
          sock_nxt      = '0;
          cnt_nxt       = '0;
        end else if (b == CH_LF || len_r >= LenLimit) begin
          // drop: not stored, not parsed
          len_nxt = len_r;
        end else begin
          len_nxt = len_r + 1'b1;
          if (len_r < LenPrefix) begin
            if (b != prefix_char(len_r[PREFIX_IDX_W-1:0])) begin
              match_nxt = 1'b0;
            end
          end else if (!sock_r.done) begin
            sock_nxt = num_step(sock_r, b);
          end
          if (b == CH_COMMA) begin
            comma_nxt = 1'b1;
            cnt_nxt   = '0;
          end else if (comma_r && !cnt_r.done) begin
            cnt_nxt = num_step(cnt_r, b);
          end
        end
      end
    end
  end

  assign out_valid_nxt = (fire && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      prev_nl_r   <= 1'b1;
      in_notice_r <= 1'b0;
      len_r       <= '0;
      match_r     <= 1'b1;
      comma_r     <= 1'b0;
      sock_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      prev_nl_r   <= prev_nl_nxt;
      in_notice_r <= in_notice_nxt;
      len_r       <= len_nxt;
      match_r     <= match_nxt;
      comma_r     <= comma_nxt;
      sock_r      <= sock_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      sock_out_r    <= sock_r.acc;
      cnt_out_r     <= comma_r ? cnt_r.acc : '0;
      present_out_r <= comma_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_socket_id     = sock_out_r;
  assign out_byte_count    = cnt_out_r;
  assign out_count_present = present_out_r;

endmodule

@@ rtl/modem_urc_notice_parser.sv @@
// A word accepted into the input register is parsed in the parser stage, and a closing
//   carriage return loads its notice into the result register. The parser takes one
//   receive word per cycle while no notice waits; the line parse state advances once
//   per word, and the parser stalls while a notice waits to be taken.
// Reset (rst_n low, synchronous): both stages empty, notices disabled, and the
//   parser treats the next byte as the first byte of a line.
module modem_urc_notice_parser import urcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] out_socket_id,
  output logic [NUM_W-1:0] out_byte_count,
  output logic             out_count_present
);

  // Word sitting in the input register, and the parser's pull on it.
  stage_word_t stage;
  logic        take;

  // Input register: capture one receive byte per cycle; hold it while the
  // result register is blocked.
  urcp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .stage_o    (stage),
    .take_i     (take)
  );

  // Parser: track line starts, match the "+NSONMI:" prefix, accumulate the
  // socket and count fields, and load the result register on the closing
  // carriage return when notices are enabled.
  urcp_parser u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .stage_i           (stage),
    .take_o            (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_socket_id     (out_socket_id),
    .out_byte_count    (out_byte_count),
    .out_count_present (out_count_present)
  );

endmodule

@@ rtl/urcp_checker.sv @@
`include "modem_urc_notice_parser_assert.svh"

module urcp_checker import urcp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [NUM_W-1:0] out_socket_id,
  input logic [NUM_W-1:0] out_byte_count,
  input logic             out_count_present
);

  // A stalled notice stays put.
  `URCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_socket_id) && $stable(out_byte_count) && $stable(out_count_present), "notice changed while stalled")

  // No count field means count zero.
  `URCP_ASSERT_NOW(a_count_absent, out_valid && !out_count_present, out_byte_count == '0, "count nonzero without a comma")

  // An empty result register never stalls the input.
  `URCP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with result side empty")

  // Taking the result frees the input side in the same cycle.
  `URCP_ASSERT_NOW(a_ready_on_take, out_valid && out_ready, in_ready, "input stalled while result taken")

endmodule

bind modem_urc_notice_parser urcp_checker u_chk (.*);
